[rtl/edcm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and helpers for the Euler ZYX attitude to body velocity block.
// Holds the CORDIC arctangent table, gain and saturating round helpers; no dependencies.
package edcm_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int TRIG_STEPS_DEF  = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  function automatic logic signed [33:0] atan_turn(input int idx);
    logic signed [33:0] r;
    unique case (idx)
      0:  r = 34'sh020000000;
      1:  r = 34'sh012E4051E;
      2:  r = 34'sh009FB385B;
      3:  r = 34'sh0051111D4;
      4:  r = 34'sh0028B0D43;
      5:  r = 34'sh00145D7E1;
      6:  r = 34'sh000A2F61E;
      7:  r = 34'sh000517C55;
      8:  r = 34'sh00028BE53;
      9:  r = 34'sh000145F2F;
      10: r = 34'sh0000A2F98;
      11: r = 34'sh0000517CC;
      12: r = 34'sh000028BE6;
      13: r = 34'sh0000145F3;
      14: r = 34'sh00000A2FA;
      15: r = 34'sh00000517D;
      16: r = 34'sh0000028BF;
      17: r = 34'sh00000145F;
      18: r = 34'sh000000A30;
      19: r = 34'sh000000518;
      20: r = 34'sh00000028C;
      21: r = 34'sh000000146;
      22: r = 34'sh0000000A3;
      23: r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // round half up from Q3.45 to Q1.15 and saturate
  function automatic logic signed [15:0] q45_to_q15(input logic signed [63:0] v);
    return sat16((v + 64'sd536870912) >>> 30);
  endfunction

  // round half up by 15 bits and saturate to Q16.16
  function automatic logic signed [31:0] vel_round(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [31:0] r;
    t = (v + 64'sd16384) >>> 15;
    if (t > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (t < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/euler_dcm_body_velocity.sv]
`timescale 1ns / 1ps
// Euler ZYX direction cosine matrix and earth to body velocity rotation, fully pipelined.
// Depends on edcm_pkg for the arctangent table, gain and rounding helpers.
//
// One attitude sample is taken every clock cycle while the output is not stalled. The stages:
// one entry stage, one CORDIC step per stage for all three angles side by side, one rounding
// stage, three stages for the matrix products and sums, two for the velocity products and sums.
// The whole pipeline holds while the output beat is not taken, so no beat is lost or repeated.
module euler_dcm_body_velocity
  import edcm_pkg::*;
#(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int TRIG_STEPS  = TRIG_STEPS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // roll_angle, pitch_angle, yaw_angle, earth_vel_x, earth_vel_y, earth_vel_z
  input  logic [((3*ANGLE_WIDTH+96+7)/8)*8-1:0]        s_tdata,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, body_vel_u, body_vel_v, body_vel_w
  output logic [239:0]                                 m_tdata
);

  localparam int NSTEP = (TRIG_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STEPS;
  localparam int NS    = NSTEP + 7;

  logic            adv;
  logic [NS-1:0]   vld;

  assign adv      = !vld[NS-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], s_tvalid};
    end
  end

  // CORDIC lanes: 0 roll, 1 pitch, 2 yaw
  logic signed [33:0] cx [0:NSTEP][3];
  logic signed [33:0] cy [0:NSTEP][3];
  logic signed [33:0] cz [0:NSTEP][3];
  logic               cneg [0:NSTEP][3];
  logic signed [31:0] vc [0:NSTEP][3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [31:0] u;
    logic [31:0] t;
    logic [31:0] u2;
    assign u  = {s_tdata[l*ANGLE_WIDTH +: ANGLE_WIDTH], (32-ANGLE_WIDTH)'(0)};
    assign t  = u + 32'h4000_0000;
    assign u2 = t[31] ? u + 32'h8000_0000 : u;

    always_ff @(posedge clk) begin
      if (adv) begin
        cx[0][l]   <= GAIN_Q30;
        cy[0][l]   <= '0;
        cz[0][l]   <= 34'(signed'(u2));
        cneg[0][l] <= t[31];
        vc[0][l]   <= s_tdata[3*ANGLE_WIDTH+32*l +: 32];
      end
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!cz[k][l][33]) begin
            cx[k+1][l] <= cx[k][l] - (cy[k][l] >>> k);
            cy[k+1][l] <= cy[k][l] + (cx[k][l] >>> k);
            cz[k+1][l] <= cz[k][l] - atan_turn(k);
          end else begin
            cx[k+1][l] <= cx[k][l] + (cy[k][l] >>> k);
            cy[k+1][l] <= cy[k][l] - (cx[k][l] >>> k);
            cz[k+1][l] <= cz[k][l] + atan_turn(k);
          end
          cneg[k+1][l] <= cneg[k][l];
          vc[k+1][l]   <= vc[k][l];
        end
      end
    end
  end

  // rounding stage
  logic signed [15:0] sn [3];
  logic signed [15:0] cs [3];
  logic signed [31:0] v1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        if (cneg[NSTEP][l]) begin
          cs[l] <= sat16((64'(-cx[NSTEP][l]) + 64'sd16384) >>> 15);
          sn[l] <= sat16((64'(-cy[NSTEP][l]) + 64'sd16384) >>> 15);
        end else begin
          cs[l] <= sat16((64'(cx[NSTEP][l]) + 64'sd16384) >>> 15);
          sn[l] <= sat16((64'(cy[NSTEP][l]) + 64'sd16384) >>> 15);
        end
        v1[l] <= vc[NSTEP][l];
      end
    end
  end

  // two-factor products
  logic signed [31:0] ctcp, ctsp, sfct, cfct, sfst, cfst, cfsp, cfcp, sfsp, sfcp;
  logic signed [15:0] st1, sp1, cp1;
  logic signed [31:0] v2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctcp <= cs[1] * cs[2];
      ctsp <= cs[1] * sn[2];
      sfct <= sn[0] * cs[1];
      cfct <= cs[0] * cs[1];
      sfst <= sn[0] * sn[1];
      cfst <= cs[0] * sn[1];
      cfsp <= cs[0] * sn[2];
      cfcp <= cs[0] * cs[2];
      sfsp <= sn[0] * sn[2];
      sfcp <= sn[0] * cs[2];
      st1  <= sn[1];
      sp1  <= sn[2];
      cp1  <= cs[2];
      v2   <= v1;
    end
  end

  // three-factor products
  logic signed [47:0] sfstcp, sfstsp, cfstcp, cfstsp;
  logic signed [31:0] ctcp2, ctsp2, sfct2, cfct2, cfsp2, cfcp2, sfsp2, sfcp2;
  logic signed [15:0] st2;
  logic signed [31:0] v3 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      sfstcp <= sfst * cp1;
      sfstsp <= sfst * sp1;
      cfstcp <= cfst * cp1;
      cfstsp <= cfst * sp1;
      ctcp2  <= ctcp;
      ctsp2  <= ctsp;
      sfct2  <= sfct;
      cfct2  <= cfct;
      cfsp2  <= cfsp;
      cfcp2  <= cfcp;
      sfsp2  <= sfsp;
      sfcp2  <= sfcp;
      st2    <= st1;
      v3     <= v2;
    end
  end

  // matrix entries
  logic signed [15:0] mq [9];
  logic signed [31:0] v4 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      mq[0] <= q45_to_q15(64'(ctcp2) <<< 15);
      mq[1] <= q45_to_q15(64'(ctsp2) <<< 15);
      mq[2] <= sat16(-64'(st2));
      mq[3] <= q45_to_q15(64'(sfstcp) - (64'(cfsp2) <<< 15));
      mq[4] <= q45_to_q15(64'(sfstsp) + (64'(cfcp2) <<< 15));
      mq[5] <= q45_to_q15(64'(sfct2) <<< 15);
      mq[6] <= q45_to_q15(64'(cfstcp) + (64'(sfsp2) <<< 15));
      mq[7] <= q45_to_q15(64'(cfstsp) - (64'(sfcp2) <<< 15));
      mq[8] <= q45_to_q15(64'(cfct2) <<< 15);
      v4    <= v3;
    end
  end

  // velocity products
  logic signed [47:0] pr [9];
  logic signed [15:0] mq5 [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        pr[i]  <= mq[i] * v4[i%3];
        mq5[i] <= mq[i];
      end
    end
  end

  // row sums and output register
  logic signed [15:0] mo [9];
  logic signed [31:0] bv [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      mo <= mq5;
      for (int r = 0; r < 3; r++) begin
        bv[r] <= vel_round(64'(pr[3*r]) + 64'(pr[3*r+1]) + 64'(pr[3*r+2]));
      end
    end
  end

  assign m_tdata = {bv[2], bv[1], bv[0], mo[8], mo[7], mo[6], mo[5], mo[4], mo[3],
                    mo[2], mo[1], mo[0]};

`ifndef SYNTHESIS
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_m02_never_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47:32] != 16'h8000)
    else $error("m02 holds the negative full scale");
  a_stall_holds_rows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(bv[0]) && $stable(mo[4]))
    else $error("result changed under stall");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for euler_dcm_body_velocity: random and directed attitude/velocity beats,
// checked against an in-bench CORDIC, DCM and body velocity predictor. Needs edcm_pkg.
module tb_top;
  import edcm_pkg::*;

  localparam int AW = 16;
  localparam int NSTEP = 16;
  localparam int LAT = NSTEP + 7;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] vz, vy, vx;
    logic signed [15:0] yaw, pitch, roll;
  } attitude_t;

  typedef struct packed {
    logic signed [31:0] w, v, u;
    logic signed [15:0] m22, m21, m20, m12, m11, m10, m02, m01, m00;
  } body_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [143:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [239:0] m_tdata;

  body_t expected_q[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_sink = 1'b0;
  bit sink_free = 1'b0;

  euler_dcm_body_velocity u_top (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_step(int i);
    longint t [24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BF, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
    return t[i];
  endfunction

  function automatic void angle_trig(input logic [15:0] ang, output longint s,
                                     output longint c);
    logic [31:0] turn;
    bit neg;
    longint x, y, z, dx, dy;
    turn = {ang, (32-AW)'(0)};
    neg = 1'b0;
    x = 652032874;
    y = 0;
    if (((turn + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      turn = turn + 32'h8000_0000;
      neg = 1'b1;
    end
    z = longint'(signed'(turn));
    for (int i = 0; i < NSTEP; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = sat(fshift(x + 16384, 15), -32768, 32767);
    s = sat(fshift(y + 16384, 15), -32768, 32767);
  endfunction

  function automatic longint q15(longint v);
    return sat(fshift(v + (64'sd1 <<< 29), 30), -32768, 32767);
  endfunction

  function automatic longint row_vel(longint a, longint b, longint c, attitude_t it);
    longint acc;
    acc = a * it.vx + b * it.vy + c * it.vz;
    return sat(fshift(acc + 16384, 15), -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic body_t rotate_to_body(attitude_t it);
    longint sf, cf, st, ct, sp, cp;
    longint m [9];
    body_t r;
    angle_trig(it.roll, sf, cf);
    angle_trig(it.pitch, st, ct);
    angle_trig(it.yaw, sp, cp);
    m[0] = q15(ct * cp * 32768);
    m[1] = q15(ct * sp * 32768);
    m[2] = q15(-st * 32768 * 32768);
    m[3] = q15(sf * st * cp - cf * sp * 32768);
    m[4] = q15(sf * st * sp + cf * cp * 32768);
    m[5] = q15(sf * ct * 32768);
    m[6] = q15(cf * st * cp + sf * sp * 32768);
    m[7] = q15(cf * st * sp - sf * cp * 32768);
    m[8] = q15(cf * ct * 32768);
    r.m00 = 16'(m[0]); r.m01 = 16'(m[1]); r.m02 = 16'(m[2]);
    r.m10 = 16'(m[3]); r.m11 = 16'(m[4]); r.m12 = 16'(m[5]);
    r.m20 = 16'(m[6]); r.m21 = 16'(m[7]); r.m22 = 16'(m[8]);
    r.u = 32'(row_vel(m[0], m[1], m[2], it));
    r.v = 32'(row_vel(m[3], m[4], m[5], it));
    r.w = 32'(row_vel(m[6], m[7], m[8], it));
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  task automatic send_beat(input attitude_t it);
    int gap;
    gap = sink_free ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= it;
    s_tvalid <= 1'b1;
    expected_q.push_back(rotate_to_body(it));
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // sink: random stalls per beat, or a long hold-off when asked
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
      end else begin
        stall = sink_free ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) stall = 0;
        if (stall != 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        m_tready <= 1'b1;
        do @(posedge clk); while (!(m_tvalid && m_tready) && !hold_sink);
      end
    end
  end

  always @(posedge clk) begin
    body_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.m00 !== want.m00) report("m00", got.m00, want.m00);
        if (got.m01 !== want.m01) report("m01", got.m01, want.m01);
        if (got.m02 !== want.m02) report("m02", got.m02, want.m02);
        if (got.m10 !== want.m10) report("m10", got.m10, want.m10);
        if (got.m11 !== want.m11) report("m11", got.m11, want.m11);
        if (got.m12 !== want.m12) report("m12", got.m12, want.m12);
        if (got.m20 !== want.m20) report("m20", got.m20, want.m20);
        if (got.m21 !== want.m21) report("m21", got.m21, want.m21);
        if (got.m22 !== want.m22) report("m22", got.m22, want.m22);
        if (got.u !== want.u) report("body_vel_u", got.u, want.u);
        if (got.v !== want.v) report("body_vel_v", got.v, want.v);
        if (got.w !== want.w) report("body_vel_w", got.w, want.w);
      end
    end
  end

  function automatic attitude_t rand_attitude();
    attitude_t it;
    it.roll = 16'($urandom);
    it.pitch = 16'($urandom);
    it.yaw = 16'($urandom);
    it.vx = $urandom;
    it.vy = $urandom;
    it.vz = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      it.vx = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      it.vy = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      it.vz = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    end
    return it;
  endfunction

  task automatic test_directed();
    logic signed [15:0] angs [8] = '{16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh4000,
                                     16'shC000, 16'sh3FFF, 16'shBFFF, 16'sh2000};
    attitude_t it;
    for (int i = 0; i < 8; i++) begin
      it.roll = angs[i];
      it.pitch = angs[(i + 3) % 8];
      it.yaw = angs[(i + 5) % 8];
      it.vx = 32'sh7FFF_FFFF;
      it.vy = 32'sh8000_0000;
      it.vz = (i % 2) ? 32'sh7FFF_FFFF : 32'sh0001_0000;
      send_beat(it);
    end
    for (int i = 0; i < 8; i++) begin
      it.roll = angs[i];
      it.pitch = angs[i];
      it.yaw = angs[i];
      it.vx = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      it.vy = it.vx;
      it.vz = it.vx;
      send_beat(it);
    end
    it = '0;
    send_beat(it);
    it = '1;
    send_beat(it);
  endtask

  task automatic test_random(input int n);
    repeat (n) send_beat(rand_attitude());
  endtask

  // hold the sink long enough for the pipeline to fill and stall the source
  task automatic test_backpressure();
    hold_sink = 1'b1;
    sink_free = 1'b1;
    fork
      repeat (3 * LAT) send_beat(rand_attitude());
      begin
        repeat (8 * LAT) @(negedge clk);
        hold_sink = 1'b0;
      end
    join
    sink_free = 1'b0;
  endtask

  task automatic test_full_rate();
    sink_free = 1'b1;
    test_random(60);
    sink_free = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(250);
    test_backpressure();
    test_full_rate();
    test_random(150);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (2 * LAT) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
